// ===== rtl/core/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;

    localparam logic [3:0] KIND_ADD = 4'd0;
    localparam logic [3:0] KIND_SUB = 4'd1;
    localparam logic [3:0] KIND_MUL = 4'd2;
    localparam logic [3:0] KIND_DIV = 4'd3;
    localparam logic [3:0] KIND_EQ  = 4'd4;
    localparam logic [3:0] KIND_LT  = 4'd5;
    localparam logic [3:0] KIND_GT  = 4'd6;
    localparam logic [3:0] KIND_LE  = 4'd7;
    localparam logic [3:0] KIND_GE  = 4'd8;

    typedef struct packed {
        logic [3:0]                    kind;
        logic signed [OPERAND_WIDTH-1:0] a_num;
        logic signed [OPERAND_WIDTH-1:0] a_den;
        logic signed [OPERAND_WIDTH-1:0] b_num;
        logic signed [OPERAND_WIDTH-1:0] b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    truth;
        logic                    div_by_zero;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic direct;
        logic gcd_done;
        logic div_done;
    } sts_t;

endpackage

// ===== rtl/core/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// rau_datapath
// operand normalize, cross products, binary gcd and shared restoring divider
// ----------------------------------------------------------------------------
module rau_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  rau_pkg::in_item_t  in_item,
    input  rau_pkg::cmd_t      cmd,
    output rau_pkg::sts_t      sts,
    output rau_pkg::out_item_t out_item
);
    import rau_pkg::*;

    localparam int W  = 64;
    localparam int OW = OPERAND_WIDTH;
    localparam int CW = 7;
    localparam int PW = 2 * OW + 2;

    logic [3:0]          kind_reg;
    logic signed [OW:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [W-1:0] lhs_reg, rhs_reg;
    logic                neg_reg;
    logic [W-1:0]        mag_reg, den_reg;
    logic [W-1:0]        gx_reg, gy_reg;
    logic [5:0]          gk_reg;
    logic [W-1:0]        quo_reg, rem_reg, dvs_reg;
    logic                pass_reg;
    logic [CW-1:0]       cnt_reg;
    out_item_t           res_item;

    logic signed [OW:0]  an_n, ad_n, bn_n, bd_n;
    logic signed [OW-1:0] ra, rb, rc, rd;
    logic signed [PW-1:0] p_anbd, p_bnad, p_anbn, p_adbd;
    logic signed [W-1:0] nsel, dsel;
    logic [W-1:0]        nmag;
    logic [W-1:0]        gcd_val;
    logic [W:0]          rsh, rsub;

    always_comb
    begin
        ra = in_item.a_num;
        rb = in_item.a_den;
        rc = in_item.b_num;
        rd = in_item.b_den;
        ad_n = (rb == '0) ? (OW+1)'(1) : (OW+1)'(rb);
        bd_n = (rd == '0) ? (OW+1)'(1) : (OW+1)'(rd);
        an_n = {ra[OW-1], ra};
        bn_n = {rc[OW-1], rc};
        if (ad_n < 0)
        begin
            ad_n = -ad_n;
            an_n = -an_n;
        end
        if (bd_n < 0)
        begin
            bd_n = -bd_n;
            bn_n = -bn_n;
        end
    end

    always_comb
    begin
        p_anbd = an_reg * bd_reg;
        p_bnad = bn_reg * ad_reg;
        p_anbn = an_reg * bn_reg;
        p_adbd = ad_reg * bd_reg;
    end

    always_comb
    begin
        case (kind_reg)
            KIND_ADD: nsel = lhs_reg + rhs_reg;
            KIND_SUB: nsel = lhs_reg - rhs_reg;
            KIND_MUL: nsel = W'(p_anbn);
            default:  nsel = (rhs_reg < 0) ? -lhs_reg : lhs_reg;
        endcase
        if (kind_reg == KIND_DIV)
            dsel = (rhs_reg < 0) ? -rhs_reg : rhs_reg;
        else
            dsel = W'(p_adbd);
        nmag = nsel[W-1] ? W'(-nsel) : W'(nsel);
        gcd_val = (gx_reg | gy_reg) << gk_reg;
        rsh  = {rem_reg, quo_reg[W-1]};
        rsub = rsh - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pass_reg <= 1'b0;
        end
        else if (cmd.div_start)
        begin
            cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(W-1))
                pass_reg <= ~pass_reg;
        end
        else if (cmd.load)
        begin
            pass_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_item.kind;
            an_reg <= an_n;
            ad_reg <= ad_n;
            bn_reg <= bn_n;
            bd_reg <= bd_n;
        end
        if (cmd.prep)
        begin
            lhs_reg <= W'(p_anbd);
            rhs_reg <= W'(p_bnad);
        end
        if (cmd.finish)
        begin
            neg_reg <= nsel[W-1];
            mag_reg <= nmag;
            den_reg <= (dsel == '0) ? W'(1) : dsel;
            gx_reg  <= nmag;
            gy_reg  <= (dsel == '0) ? W'(1) : dsel;
            gk_reg  <= '0;
        end
        if (cmd.gcd_step)
        begin
            // common factors of two, then odd-odd differences
            if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                gk_reg <= gk_reg + 1'b1;
            end
            else if (!gx_reg[0])
                gx_reg <= gx_reg >> 1;
            else if (!gy_reg[0])
                gy_reg <= gy_reg >> 1;
            else if (gx_reg >= gy_reg)
                gx_reg <= (gx_reg - gy_reg) >> 1;
            else
                gy_reg <= (gy_reg - gx_reg) >> 1;
        end
        if (cmd.div_start)
        begin
            quo_reg <= pass_reg ? den_reg : mag_reg;
            rem_reg <= '0;
            dvs_reg <= gcd_val;
        end
        if (cmd.div_step)
        begin
            if (!rsub[W])
            begin
                rem_reg <= rsub[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rsh[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
            if (cnt_reg == CW'(W-1))
            begin
                if (!pass_reg)
                    mag_reg <= rsub[W] ? {quo_reg[W-2:0], 1'b0}
                                       : {quo_reg[W-2:0], 1'b1};
                else
                    den_reg <= rsub[W] ? {quo_reg[W-2:0], 1'b0}
                                       : {quo_reg[W-2:0], 1'b1};
            end
        end
    end

    always_comb
    begin
        sts.direct   = (kind_reg > KIND_DIV) || (kind_reg == KIND_DIV && bn_reg == '0);
        sts.gcd_done = (gx_reg == '0) || (gy_reg == '0);
        sts.div_done = (cnt_reg == CW'(W));
    end

    always_comb
    begin
        res_item = '0;
        res_item.res_den = DEN_W'(1);
        case (kind_reg)
            KIND_EQ: res_item.truth = (lhs_reg == rhs_reg);
            KIND_LT: res_item.truth = (lhs_reg < rhs_reg);
            KIND_GT: res_item.truth = (lhs_reg > rhs_reg);
            KIND_LE: res_item.truth = (lhs_reg <= rhs_reg);
            KIND_GE: res_item.truth = (lhs_reg >= rhs_reg);
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV:
            begin
                if (kind_reg == KIND_DIV && bn_reg == '0)
                begin
                    res_item.res_num = NUM_W'(1);
                    res_item.div_by_zero = 1'b1;
                end
                else if (mag_reg != '0)
                begin
                    res_item.res_num = neg_reg ? NUM_W'(-mag_reg) : NUM_W'(mag_reg);
                    res_item.res_den = den_reg[DEN_W-1:0];
                end
            end
            default: res_item.truth = 1'b0;
        endcase
        out_item = res_item;
    end

endmodule

// ===== rtl/core/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer: load, products, gcd loop, two divisions, output hold
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  rau_pkg::sts_t  sts,
    output rau_pkg::cmd_t  cmd
);
    import rau_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PROD = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_GCD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       second_reg, second_next;

    always_comb
    begin
        state_next = state_reg;
        second_next = second_reg;
        cmd = '0;
        in_ready = (state_reg == S_IDLE);
        out_valid = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_PROD;
                end
            S_PROD:
            begin
                cmd.prep = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.finish = 1'b1;
                state_next = sts.direct ? S_OUT : S_GCD;
            end
            S_GCD:
                if (sts.gcd_done)
                begin
                    cmd.div_start = 1'b1;
                    second_next = 1'b0;
                    state_next = S_DIV;
                end
                else
                    cmd.gcd_step = 1'b1;
            S_DIV:
                if (sts.div_done)
                begin
                    if (second_reg)
                        state_next = S_OUT;
                    else
                    begin
                        // numerator done, start on the denominator
                        cmd.div_start = 1'b1;
                        second_next = 1'b1;
                    end
                end
                else
                    cmd.div_step = 1'b1;
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            second_reg <= second_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("accept while holding result");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.prep, cmd.finish, cmd.gcd_step, cmd.div_step}))
        else $error("overlapping commands");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_PROD) else $error("load without products");

endmodule

// ===== rtl/core/rational_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// two fractions in, one reduced fraction or comparison bit out
// ----------------------------------------------------------------------------
// in_valid/in_ready carry one operation with two signed fractions; out_valid/
// out_ready carry one result per transfer. one item is worked at a time, so
// in_ready is high only while the block is idle.
// comparisons, unused kinds and division by zero go from the cross products
// straight to the result. arithmetic kinds add a binary gcd loop (each step
// drops at least one bit of the operands) and two 64-bit restoring
// divisions by the gcd, first the numerator and then the denominator.
// after the output transfer the block returns to idle before it can take
// the next item.
// reset clears the sequencer; the block comes up ready with no result.
// while the receiver stalls the result is held and no new item is taken.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rau_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rau_pkg::out_item_t out_data
);
    import rau_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rau_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .sts(sts), .cmd(cmd)
    );

    rau_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_item(in_data), .cmd(cmd), .sts(sts), .out_item(out_data)
    );

endmodule

// ===== test/rau_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rau_result_checker
// watches both channels, predicts each result and compares it on arrival
// ----------------------------------------------------------------------------
// every input transfer pushes one predicted result; every output transfer is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rau_result_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  rau_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  rau_pkg::out_item_t out_data,
    output int                 fail_count,
    output int                 pending
);
    import rau_pkg::*;

    out_item_t fraction_q[$];

    function automatic out_item_t reduce_fraction(logic signed [63:0] n, logic [63:0] d);
        out_item_t r;
        logic [63:0] mag;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic        neg;
        r = '0;
        r.res_den = DEN_W'(1);
        neg = n[63];
        mag = neg ? -n : n;
        if (d == 0)
            d = 64'd1;
        if (mag == 0)
            return r;
        x = mag;
        y = d;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        mag = mag / x;
        d = d / x;
        r.res_num = neg ? NUM_W'(-mag) : NUM_W'(mag);
        r.res_den = d[DEN_W-1:0];
        return r;
    endfunction

    function automatic out_item_t predict_fraction(in_item_t it);
        out_item_t r;
        logic signed [63:0] an;
        logic signed [63:0] ad;
        logic signed [63:0] bn;
        logic signed [63:0] bd;
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
        r = '0;
        r.res_den = DEN_W'(1);
        an = it.a_num;
        ad = it.a_den;
        bn = it.b_num;
        bd = it.b_den;
        if (ad == 0)
            ad = 64'sd1;
        if (ad < 0)
        begin
            ad = -ad;
            an = -an;
        end
        if (bd == 0)
            bd = 64'sd1;
        if (bd < 0)
        begin
            bd = -bd;
            bn = -bn;
        end
        lhs = an * bd;
        rhs = bn * ad;
        case (it.kind)
            KIND_ADD: r = reduce_fraction(lhs + rhs, ad * bd);
            KIND_SUB: r = reduce_fraction(lhs - rhs, ad * bd);
            KIND_MUL: r = reduce_fraction(an * bn, ad * bd);
            KIND_DIV:
                if (bn == 0)
                begin
                    r.res_num = NUM_W'(1);
                    r.div_by_zero = 1'b1;
                end
                else if (rhs < 0)
                    r = reduce_fraction(-lhs, -rhs);
                else
                    r = reduce_fraction(lhs, rhs);
            KIND_EQ: r.truth = (lhs == rhs);
            KIND_LT: r.truth = (lhs < rhs);
            KIND_GT: r.truth = (lhs > rhs);
            KIND_LE: r.truth = (lhs <= rhs);
            KIND_GE: r.truth = (lhs >= rhs);
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        out_item_t exp_item;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                fraction_q.push_back(predict_fraction(in_data));
            if (out_valid && out_ready)
            begin
                if (fraction_q.size() == 0)
                begin
                    $error("result with no prediction waiting: %p", out_data);
                    fail_count++;
                end
                else
                begin
                    exp_item = fraction_q.pop_front();
                    if (out_data.res_num !== exp_item.res_num)
                    begin
                        $error("res_num expected %0d actual %0d",
                               exp_item.res_num, out_data.res_num);
                        fail_count++;
                    end
                    if (out_data.res_den !== exp_item.res_den)
                    begin
                        $error("res_den expected %0d actual %0d",
                               exp_item.res_den, out_data.res_den);
                        fail_count++;
                    end
                    if (out_data.truth !== exp_item.truth)
                    begin
                        $error("truth expected %0b actual %0b",
                               exp_item.truth, out_data.truth);
                        fail_count++;
                    end
                    if (out_data.div_by_zero !== exp_item.div_by_zero)
                    begin
                        $error("div_by_zero expected %0b actual %0b",
                               exp_item.div_by_zero, out_data.div_by_zero);
                        fail_count++;
                    end
                end
            end
            pending = fraction_q.size();
        end
    end
endmodule

// ===== test/tb_rational_arithmetic_unit_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit_core
// stimulus and verdict for the rational arithmetic unit
// ----------------------------------------------------------------------------
// directed corner operands, then random fractions over all kinds, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit_core;
    import rau_pkg::*;

    localparam int N_RANDOM    = 1330;
    localparam int CYCLE_LIMIT = 2000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    int        fail_count;
    int        pending;
    int        cycle_count;
    logic      stim_done;

    rational_arithmetic_unit_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    rau_result_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4, 5: return 16'($signed($urandom_range(0, 40)) - 20);
            6, 7: return 16'($signed($urandom_range(0, 2000)) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_fraction(logic [3:0] kind, logic [15:0] an, logic [15:0] ad,
                                 logic [15:0] bn, logic [15:0] bd);
        int gap;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data <= '{kind, an, ad, bn, bd};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    initial
    begin
        in_valid = 1'b0;
        in_data = '0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_fraction(KIND_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
        send_fraction(KIND_SUB, 16'h8000, 16'h0001, 16'h7fff, 16'h0001);
        send_fraction(KIND_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
        send_fraction(KIND_DIV, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_fraction(KIND_DIV, 16'h0003, 16'h0004, 16'h0000, 16'h0005);
        send_fraction(KIND_ADD, 16'h0001, 16'h0000, 16'h0002, 16'h0000);
        send_fraction(KIND_SUB, 16'h0005, 16'hfffd, 16'h0005, 16'hfffd);
        send_fraction(KIND_MUL, 16'h0000, 16'h0007, 16'h1234, 16'hffff);
        send_fraction(KIND_DIV, 16'h0006, 16'hfffc, 16'hfffd, 16'h0002);
        send_fraction(KIND_EQ, 16'h0001, 16'h0002, 16'h0002, 16'h0004);
        send_fraction(KIND_EQ, 16'h0001, 16'h0002, 16'h0002, 16'h0005);
        send_fraction(KIND_LT, 16'hffff, 16'h0002, 16'h0001, 16'hfffe);
        send_fraction(KIND_GT, 16'h0001, 16'h0003, 16'h0001, 16'h0004);
        send_fraction(KIND_LE, 16'h0002, 16'hfffc, 16'h0001, 16'hfffe);
        send_fraction(KIND_GE, 16'h8000, 16'h0001, 16'h7fff, 16'h0001);
        send_fraction(KIND_LT, 16'h0005, 16'h0000, 16'h0005, 16'h0001);
        send_fraction(4'd9, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
        send_fraction(4'd15, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_fraction(KIND_DIV, 16'h7fff, 16'h0001, 16'h8000, 16'h0000);
        send_fraction(KIND_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        repeat (N_RANDOM)
        begin
            logic [3:0] k;
            k = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
            send_fraction(k, pick_operand(), pick_operand(), pick_operand(), pick_operand());
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver stalls drawn per result
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
